>>> src/sarw_pkg.sv
// Shared types and codes for the selective-ack receive window.
package sarw_pkg;

  localparam int CFG_IDX_W = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_CHUNKS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RESUME_PREFIX   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACK_GAP_MS      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_READVERTISE_MS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT_MS = 3'd4;

  localparam logic [15:0] ACK_GAP_RST      = 16'd40;
  localparam logic [15:0] READVERTISE_RST  = 16'd120;
  localparam logic [15:0] IDLE_TIMEOUT_RST = 16'd8000;

  // input word kinds
  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_DATA  = 2'd1;
  localparam logic [1:0] KIND_NUDGE = 2'd2;
  localparam logic [1:0] KIND_TICK  = 2'd3;

  // link states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;
  localparam logic [1:0] ST_FAIL = 2'd3;

  // failure reasons
  localparam logic [1:0] WHY_NONE     = 2'd0;
  localparam logic [1:0] WHY_DECLINED = 2'd1;
  localparam logic [1:0] WHY_CHECK    = 2'd2;
  localparam logic [1:0] WHY_TIMEOUT  = 2'd3;

  typedef struct packed {
    logic [31:0] total_chunks;
    logic [31:0] resume_prefix;
    logic [15:0] ack_gap_ms;
    logic [15:0] readvertise_ms;
    logic [15:0] idle_timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] seq;
    logic [31:0] now_ms;
    logic        accept;
    logic        verify_ok;
  } in_item_t;

  typedef struct packed {
    logic        store_chunk;
    logic [31:0] store_seq;
    logic        ack_due;
    logic [31:0] win_base;
    logic [31:0] ack_mask;
    logic        fin_due;
    logic        fin_ok;
    logic [1:0]  link_state;
    logic [1:0]  fail_reason;
  } result_t;

endpackage

>>> src/sarw_if.sv
// Handshake channel interfaces: input words, result words, configuration writes.
interface sarw_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] seq;
  logic [31:0] now_ms;
  logic        accept;
  logic        verify_ok;
  modport source (output valid, kind, seq, now_ms, accept, verify_ok, input ready);
  modport sink   (input valid, kind, seq, now_ms, accept, verify_ok, output ready);
endinterface

interface sarw_out_if;
  logic        valid;
  logic        ready;
  logic        store_chunk;
  logic [31:0] store_seq;
  logic        ack_due;
  logic [31:0] win_base;
  logic [31:0] ack_mask;
  logic        fin_due;
  logic        fin_ok;
  logic [1:0]  link_state;
  logic [1:0]  fail_reason;
  modport source (output valid, store_chunk, store_seq, ack_due, win_base, ack_mask,
                  fin_due, fin_ok, link_state, fail_reason, input ready);
  modport sink   (input valid, store_chunk, store_seq, ack_due, win_base, ack_mask,
                  fin_due, fin_ok, link_state, fail_reason, output ready);
endinterface

interface sarw_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> src/sarw_cfg.sv
// Configuration register file for the receive window.
module sarw_cfg import sarw_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  sarw_cfg_if.sink   cfg_ch,
  output cfg_t       cfg
);

  cfg_t cfg_r;

  assign cfg_ch.ready = 1'b1;
  assign cfg             = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.total_chunks    <= '0;
      cfg_r.resume_prefix   <= '0;
      cfg_r.ack_gap_ms      <= ACK_GAP_RST;
      cfg_r.readvertise_ms  <= READVERTISE_RST;
      cfg_r.idle_timeout_ms <= IDLE_TIMEOUT_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_TOTAL_CHUNKS:    cfg_r.total_chunks    <= cfg_ch.data;
        REG_RESUME_PREFIX:   cfg_r.resume_prefix   <= cfg_ch.data;
        REG_ACK_GAP_MS:      cfg_r.ack_gap_ms      <= cfg_ch.data[15:0];
        REG_READVERTISE_MS:  cfg_r.readvertise_ms  <= cfg_ch.data[15:0];
        REG_IDLE_TIMEOUT_MS: cfg_r.idle_timeout_ms <= cfg_ch.data[15:0];
        default: ;
      endcase
    end
  end

endmodule

>>> src/sarw_absorb.sv
// Window bitmap update: mark a received chunk and absorb the contiguous run at the base.
module sarw_absorb #(
  parameter int WINDOW_BITS = 32
) (
  input  logic [WINDOW_BITS-1:0] map_in,
  input  logic [31:0]            off,
  input  logic                   in_window,
  output logic                   store,
  output logic [WINDOW_BITS-1:0] map_out,
  output logic [31:0]            adv
);

  localparam int IDX_W = (WINDOW_BITS > 1) ? $clog2(WINDOW_BITS) : 1;
  localparam int CNT_W = $clog2(WINDOW_BITS + 1);

  logic [WINDOW_BITS-1:0] sel;
  logic [WINDOW_BITS-1:0] map_set;
  logic [CNT_W-1:0]       ones;
  logic [WINDOW_BITS:0]   map_ext;

  assign sel     = {{(WINDOW_BITS-1){1'b0}}, 1'b1} << off[IDX_W-1:0];
  assign store   = in_window && ((off == 32'd0) || ((map_in & sel) == '0));
  assign map_set = map_in | sel;

  // trailing ones: index of the lowest clear bit, or the full width
  always_comb begin
    ones = CNT_W'(WINDOW_BITS);
    for (int i = WINDOW_BITS - 1; i >= 0; i--) begin
      if (!map_set[i]) ones = CNT_W'(i);
    end
  end

  assign map_ext = {1'b0, map_set} >> ones;

  always_comb begin
    if (in_window) begin
      map_out = map_ext[WINDOW_BITS-1:0];
      adv     = 32'(ones);
    end else begin
      map_out = map_in;
      adv     = 32'd0;
    end
  end

endmodule

>>> src/selective_ack_receive_window_core.sv
// Selective-repeat receive window: top level with input register, state and result register.
//
//  channel   dir  handshake      carries
//  in_ch     in   valid/ready    kind, seq, now_ms, accept, verify_ok
//  out_ch    out  valid/ready    store/ack/fin flags, ack base and mask, state, reason
//  cfg_ch    in   valid/ready    register index and write data (always ready)
//
// One word per cycle sustained while out_ch takes results; a result passes from the input
// register through the window update logic into the result register.
// Reset clears both valids, the link state, the window and the configuration to defaults.
// A stalled result holds in the output register while one more word waits in the
// input register; the input side stalls only when both are full.
module selective_ack_receive_window_core import sarw_pkg::*; #(
  parameter int WINDOW_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  sarw_in_if.sink     in_ch,
  sarw_out_if.source  out_ch,
  sarw_cfg_if.sink    cfg_ch
);

  localparam int MASK_W = (WINDOW_BITS < 32) ? WINDOW_BITS : 32;

  cfg_t cfg;

  logic     in_v_r;
  in_item_t in_item_r;
  logic     out_v_r;
  result_t  out_res_r;
  logic     step;

  logic [1:0]             state_r, state_nxt;
  logic [1:0]             reason_r, reason_nxt;
  logic [31:0]            base_r, base_nxt;
  logic [WINDOW_BITS-1:0] map_r, map_nxt;
  logic [31:0]            ack_t_r, ack_t_nxt;
  logic [31:0]            rx_t_r, rx_t_nxt;
  result_t                res;

  logic [31:0]            off;
  logic                   behind;
  logic                   in_window;
  logic                   ab_store;
  logic [WINDOW_BITS-1:0] ab_map;
  logic [31:0]            ab_adv;
  logic [31:0]            base_upd;
  logic [31:0]            start_base;
  logic [31:0]            ack_age;
  logic [31:0]            rx_age;

  sarw_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  // ---- input register
  assign step        = in_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !in_v_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_item_r.kind      <= in_ch.kind;
      in_item_r.seq       <= in_ch.seq;
      in_item_r.now_ms    <= in_ch.now_ms;
      in_item_r.accept    <= in_ch.accept;
      in_item_r.verify_ok <= in_ch.verify_ok;
    end
  end

  // ---- window update
  assign off       = in_item_r.seq - base_r;
  assign behind    = in_item_r.seq < base_r;
  assign in_window = !behind && (off < 32'(WINDOW_BITS));

  sarw_absorb #(.WINDOW_BITS(WINDOW_BITS)) u_absorb (
    .map_in    (map_r),
    .off       (off),
    .in_window (in_window),
    .store     (ab_store),
    .map_out   (ab_map),
    .adv       (ab_adv)
  );

  assign base_upd   = base_r + ab_adv;
  assign start_base = (cfg.resume_prefix > cfg.total_chunks) ? cfg.total_chunks
                                                             : cfg.resume_prefix;
  assign ack_age    = in_item_r.now_ms - ack_t_r;
  assign rx_age     = in_item_r.now_ms - rx_t_r;

  always_comb begin
    state_nxt  = state_r;
    reason_nxt = reason_r;
    base_nxt   = base_r;
    map_nxt    = map_r;
    ack_t_nxt  = ack_t_r;
    rx_t_nxt   = rx_t_r;
    res        = '0;

    unique case (in_item_r.kind)
      KIND_START: begin
        if (state_r != ST_RUN) begin
          if (!in_item_r.accept) begin
            if (state_r == ST_IDLE) begin
              state_nxt  = ST_FAIL;
              reason_nxt = WHY_DECLINED;
            end
          end else begin
            base_nxt   = start_base;
            map_nxt    = '0;
            state_nxt  = ST_RUN;
            reason_nxt = WHY_NONE;
            rx_t_nxt   = in_item_r.now_ms;
            ack_t_nxt  = in_item_r.now_ms;
            // nothing left to fetch: finish straight away
            if (start_base == cfg.total_chunks) begin
              res.fin_due = 1'b1;
              res.fin_ok  = in_item_r.verify_ok;
              if (in_item_r.verify_ok) begin
                state_nxt = ST_DONE;
              end else begin
                state_nxt  = ST_FAIL;
                reason_nxt = WHY_CHECK;
              end
            end
          end
        end
      end
      KIND_DATA: begin
        if ((state_r == ST_RUN || state_r == ST_DONE) && (behind || in_window)) begin
          res.store_chunk = ab_store;
          res.store_seq   = ab_store ? in_item_r.seq : 32'd0;
          base_nxt        = base_upd;
          map_nxt         = ab_map;
          rx_t_nxt        = in_item_r.now_ms;
          if (base_upd == cfg.total_chunks) begin
            res.ack_due = 1'b1;
            ack_t_nxt   = in_item_r.now_ms;
            res.fin_due = 1'b1;
            res.fin_ok  = in_item_r.verify_ok;
            if (in_item_r.verify_ok) begin
              state_nxt = ST_DONE;
            end else if (state_r == ST_RUN) begin
              state_nxt  = ST_FAIL;
              reason_nxt = WHY_CHECK;
            end
          end else if ((base_upd != base_r) || (ack_age >= 32'(cfg.ack_gap_ms))) begin
            res.ack_due = 1'b1;
            ack_t_nxt   = in_item_r.now_ms;
          end
        end
      end
      KIND_NUDGE: begin
        res.ack_due = 1'b1;
        ack_t_nxt   = in_item_r.now_ms;
        if (base_r == cfg.total_chunks) begin
          res.fin_due = 1'b1;
          res.fin_ok  = 1'b1;
        end
      end
      KIND_TICK: begin
        if (state_r == ST_RUN) begin
          if (rx_age > 32'(cfg.idle_timeout_ms)) begin
            state_nxt  = ST_FAIL;
            reason_nxt = WHY_TIMEOUT;
          end else if (ack_age >= 32'(cfg.readvertise_ms)) begin
            res.ack_due = 1'b1;
            ack_t_nxt   = in_item_r.now_ms;
          end
        end
      end
      default: ;
    endcase

    res.win_base    = base_nxt;
    res.ack_mask    = 32'(map_nxt[MASK_W-1:0]);
    res.link_state  = state_nxt;
    res.fail_reason = reason_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      reason_r <= WHY_NONE;
      base_r   <= '0;
      map_r    <= '0;
      ack_t_r  <= '0;
      rx_t_r   <= '0;
    end else if (step) begin
      state_r  <= state_nxt;
      reason_r <= reason_nxt;
      base_r   <= base_nxt;
      map_r    <= map_nxt;
      ack_t_r  <= ack_t_nxt;
      rx_t_r   <= rx_t_nxt;
    end
  end

  // ---- result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (step) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.store_chunk = out_res_r.store_chunk;
  assign out_ch.store_seq   = out_res_r.store_seq;
  assign out_ch.ack_due     = out_res_r.ack_due;
  assign out_ch.win_base    = out_res_r.win_base;
  assign out_ch.ack_mask    = out_res_r.ack_mask;
  assign out_ch.fin_due     = out_res_r.fin_due;
  assign out_ch.fin_ok      = out_res_r.fin_ok;
  assign out_ch.link_state  = out_res_r.link_state;
  assign out_ch.fail_reason = out_res_r.fail_reason;

`ifndef ASSERT_OFF
  // a held word must not be dropped while the result side stalls
  a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && !step |=> in_v_r)
    else $error("input word lost under stall");

  // a reason is recorded exactly when the link has failed
  a_reason_fail: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FAIL) == (reason_r != WHY_NONE))
    else $error("fail reason out of step with link state");

  // the base chunk is always absorbed into base_r
  a_base_absorbed: assert property (@(posedge clk) disable iff (!rst_n)
    !map_r[0])
    else $error("window bit at base left set");

  a_fin_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_res_r.fin_ok |-> out_res_r.fin_due)
    else $error("FIN verdict without FIN");

  a_store_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_res_r.store_chunk |->
      (out_res_r.link_state == ST_RUN || out_res_r.link_state == ST_DONE ||
       out_res_r.link_state == ST_FAIL))
    else $error("chunk stored while idle");
`endif

endmodule
